@@ hdl/pwbs_pkg.sv @@
// Shared types, constants and duration scaling for the pulse-width bit serializer.
`timescale 1ns / 1ps
`default_nettype none

package pwbs_pkg;

    // Width of the four bit-timing registers
    localparam int TIMING_BITS = 16;
    localparam int TIME_BITS   = 30;
    localparam int PROD_BITS   = TIMING_BITS + 14;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Configuration register indexes
    localparam logic [2:0] REG_ZERO_HIGH = 3'd0;
    localparam logic [2:0] REG_ZERO_LOW  = 3'd1;
    localparam logic [2:0] REG_ONE_HIGH  = 3'd2;
    localparam logic [2:0] REG_ONE_LOW   = 3'd3;
    localparam logic [2:0] REG_UNIT      = 3'd4;
    localparam logic [2:0] REG_CAL       = 3'd5;

    // Time unit codes
    localparam logic [1:0] UNIT_MS      = 2'd0;
    localparam logic [1:0] UNIT_US      = 2'd1;
    localparam logic [1:0] UNIT_100NS   = 2'd2;
    localparam logic [1:0] UNIT_INVALID = 2'd3;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Pin phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    // Reset values of the registers
    localparam logic [TIMING_BITS-1:0] RST_ZERO_HIGH = TIMING_BITS'(4);
    localparam logic [TIMING_BITS-1:0] RST_ZERO_LOW  = TIMING_BITS'(8);
    localparam logic [TIMING_BITS-1:0] RST_ONE_HIGH  = TIMING_BITS'(8);
    localparam logic [TIMING_BITS-1:0] RST_ONE_LOW   = TIMING_BITS'(4);
    localparam logic [1:0]             RST_UNIT      = UNIT_100NS;
    localparam logic [7:0]             RST_CAL       = 8'd0;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // One classified item handed from the front to the back
    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
        logic       last;
    } t_item;

    // Phase lengths in 100 ns ticks, ready for the back end
    typedef struct packed {
        logic [TIME_BITS-1:0] zero_high;
        logic [TIME_BITS-1:0] zero_low;
        logic [TIME_BITS-1:0] one_high;
        logic [TIME_BITS-1:0] one_low;
    } t_durations;

    // Scale a duration into ticks: unit multiply, calibrated subtract or one for an invalid unit,
    // then raise zero to one and saturate
    function automatic logic [TIME_BITS-1:0] ticks_for(
        input logic [TIMING_BITS-1:0] v,
        input logic [1:0]             unit,
        input logic [7:0]             cal
    );
        logic [PROD_BITS-1:0]   d;
        logic [TIMING_BITS-1:0] cal_w;
        logic [TIME_BITS-1:0]   r;
        cal_w = TIMING_BITS'(cal);
        unique case (unit)
            UNIT_MS:    d = PROD_BITS'(v) * PROD_BITS'(10000);
            UNIT_US:    d = PROD_BITS'(v) * PROD_BITS'(10);
            UNIT_100NS: d = (v > cal_w) ? PROD_BITS'(v - cal_w) : '0;
            default:    d = PROD_BITS'(1);
        endcase
        if (d == '0) begin
            r = TIME_BITS'(1);
        end else if (d > PROD_BITS'(TIME_MAX)) begin
            r = TIME_MAX;
        end else begin
            r = d[TIME_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/pwbs_cfg.sv @@
// Configuration registers and pre-scaled phase lengths.
`timescale 1ns / 1ps
`default_nettype none

module pwbs_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [2:0]                     i_cfg_index,
    input  wire logic [pwbs_pkg::TIMING_BITS-1:0] i_cfg_wdata,
    output pwbs_pkg::t_durations                o_dur,
    output logic                                o_unit_invalid
);

    logic [pwbs_pkg::TIMING_BITS-1:0] r_zero_high, r_zero_low, r_one_high, r_one_low;
    logic [1:0]                       r_unit;
    logic [7:0]                       r_cal;
    pwbs_pkg::t_durations             r_dur, n_dur;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_high <= pwbs_pkg::RST_ZERO_HIGH;
            r_zero_low  <= pwbs_pkg::RST_ZERO_LOW;
            r_one_high  <= pwbs_pkg::RST_ONE_HIGH;
            r_one_low   <= pwbs_pkg::RST_ONE_LOW;
            r_unit      <= pwbs_pkg::RST_UNIT;
            r_cal       <= pwbs_pkg::RST_CAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pwbs_pkg::REG_ZERO_HIGH: r_zero_high <= i_cfg_wdata;
                pwbs_pkg::REG_ZERO_LOW:  r_zero_low  <= i_cfg_wdata;
                pwbs_pkg::REG_ONE_HIGH:  r_one_high  <= i_cfg_wdata;
                pwbs_pkg::REG_ONE_LOW:   r_one_low   <= i_cfg_wdata;
                pwbs_pkg::REG_UNIT:      r_unit      <= i_cfg_wdata[1:0];
                pwbs_pkg::REG_CAL:       r_cal       <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Scaled lengths, registered in the cycle after the registers change
    always_comb begin
        n_dur.zero_high = pwbs_pkg::ticks_for(r_zero_high, r_unit, r_cal);
        n_dur.zero_low  = pwbs_pkg::ticks_for(r_zero_low,  r_unit, r_cal);
        n_dur.one_high  = pwbs_pkg::ticks_for(r_one_high,  r_unit, r_cal);
        n_dur.one_low   = pwbs_pkg::ticks_for(r_one_low,   r_unit, r_cal);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur.zero_high <= pwbs_pkg::ticks_for(pwbs_pkg::RST_ZERO_HIGH,
                                                   pwbs_pkg::RST_UNIT, pwbs_pkg::RST_CAL);
            r_dur.zero_low  <= pwbs_pkg::ticks_for(pwbs_pkg::RST_ZERO_LOW,
                                                   pwbs_pkg::RST_UNIT, pwbs_pkg::RST_CAL);
            r_dur.one_high  <= pwbs_pkg::ticks_for(pwbs_pkg::RST_ONE_HIGH,
                                                   pwbs_pkg::RST_UNIT, pwbs_pkg::RST_CAL);
            r_dur.one_low   <= pwbs_pkg::ticks_for(pwbs_pkg::RST_ONE_LOW,
                                                   pwbs_pkg::RST_UNIT, pwbs_pkg::RST_CAL);
        end else begin
            r_dur <= n_dur;
        end
    end

    assign o_dur          = r_dur;
    assign o_unit_invalid = (r_unit == pwbs_pkg::UNIT_INVALID);

endmodule

`default_nettype wire

@@ hdl/pwbs_front.sv @@
// Input side: accepts transactions, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module pwbs_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_last_byte,
    output logic            o_q_valid,
    output pwbs_pkg::t_item o_q_item,
    input  wire logic       i_q_pop
);

    pwbs_pkg::t_item r_mem [2];
    logic [1:0]      r_count, n_count;
    logic            r_wr_ptr, r_rd_ptr;
    logic            w_push;
    pwbs_pkg::t_item w_item;

    // Classify the incoming request
    always_comb begin
        w_item.is_tick = (i_req_type == pwbs_pkg::REQ_TICK);
        w_item.data    = i_byte_value;
        w_item.last    = i_last_byte;
    end

    assign o_in_stall = (r_count == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    // Queue pointers and fill count
    always_comb begin
        n_count = r_count;
        if (w_push && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_push) r_wr_ptr <= !r_wr_ptr;
            if (i_q_pop) r_rd_ptr <= !r_rd_ptr;
        end
    end

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

@@ hdl/pwbs_back.sv @@
// Back end: bit sequencer, holding buffer and registered result.
`timescale 1ns / 1ps
`default_nettype none

module pwbs_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire pwbs_pkg::t_item      i_q_item,
    output logic                      o_q_pop,
    input  wire pwbs_pkg::t_durations i_dur,
    input  wire logic                 i_unit_invalid,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_pin_level,
    output logic                      o_buffer_ready,
    output logic                      o_busy_res,
    output logic                      o_transfer_done,
    output logic                      o_byte_rejected
);

    localparam int TB = pwbs_pkg::TIME_BITS;

    logic [7:0]    r_shift, n_shift;
    logic [3:0]    r_bits, n_bits;
    logic [1:0]    r_phase, n_phase;
    logic [TB-1:0] r_time, n_time;
    logic          r_cur_last, n_cur_last;
    logic [7:0]    r_held, n_held;
    logic          r_held_valid, n_held_valid;
    logic          r_held_last, n_held_last;
    logic          w_done, w_rejected, w_busy;
    logic [TB-1:0] w_time_dec;
    logic [3:0]    w_bits_dec;
    logic [7:0]    w_shift_next;

    logic r_out_valid, r_pin, r_ready, r_busy, r_done, r_rej;

    // Take an item whenever the result register is free or draining
    assign o_q_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    // Next state for one transaction
    always_comb begin
        n_shift      = r_shift;
        n_bits       = r_bits;
        n_phase      = r_phase;
        n_time       = r_time;
        n_cur_last   = r_cur_last;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_held_last  = r_held_last;
        w_done       = 1'b0;
        w_rejected   = 1'b0;
        w_busy       = (r_phase == pwbs_pkg::PH_HIGH) || (r_phase == pwbs_pkg::PH_LOW);
        w_time_dec   = (r_time != '0) ? r_time - TB'(1) : r_time;
        w_bits_dec   = (r_bits != 4'd0) ? r_bits - 4'd1 : r_bits;
        w_shift_next = {r_shift[6:0], 1'b0};

        if (!i_q_item.is_tick) begin
            // Byte load
            if (i_unit_invalid || r_held_valid) begin
                w_rejected = 1'b1;
            end else if (w_busy) begin
                n_held       = i_q_item.data;
                n_held_last  = i_q_item.last;
                n_held_valid = 1'b1;
            end else begin
                n_held     = i_q_item.data;
                n_shift    = i_q_item.data;
                n_cur_last = i_q_item.last;
                n_bits     = pwbs_pkg::BITS_PER_BYTE;
                n_phase    = pwbs_pkg::PH_HIGH;
                n_time     = i_q_item.data[7] ? i_dur.one_high : i_dur.zero_high;
            end
        end else if (w_busy) begin
            // Tick while a bit is being timed
            n_time = w_time_dec;
            if (w_time_dec == '0) begin
                if (r_phase == pwbs_pkg::PH_HIGH) begin
                    n_phase = pwbs_pkg::PH_LOW;
                    n_time  = r_shift[7] ? i_dur.one_low : i_dur.zero_low;
                end else begin
                    n_shift = w_shift_next;
                    n_bits  = w_bits_dec;
                    if (w_bits_dec != 4'd0) begin
                        n_phase = pwbs_pkg::PH_HIGH;
                        n_time  = w_shift_next[7] ? i_dur.one_high : i_dur.zero_high;
                    end else begin
                        w_done     = r_cur_last;
                        n_cur_last = 1'b0;
                        if (r_held_valid) begin
                            n_shift      = r_held;
                            n_cur_last   = r_held_last;
                            n_held_valid = 1'b0;
                            n_bits       = pwbs_pkg::BITS_PER_BYTE;
                            n_phase      = pwbs_pkg::PH_HIGH;
                            n_time       = r_held[7] ? i_dur.one_high : i_dur.zero_high;
                        end else begin
                            n_phase = pwbs_pkg::PH_IDLE;
                            n_time  = '0;
                        end
                    end
                end
            end
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift      <= 8'd0;
            r_bits       <= 4'd0;
            r_phase      <= pwbs_pkg::PH_IDLE;
            r_time       <= '0;
            r_cur_last   <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_last  <= 1'b0;
        end else if (o_q_pop) begin
            r_shift      <= n_shift;
            r_bits       <= n_bits;
            r_phase      <= n_phase;
            r_time       <= n_time;
            r_cur_last   <= n_cur_last;
            r_held_valid <= n_held_valid;
            r_held_last  <= n_held_last;
        end
    end

    // Holding buffer data
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_held <= n_held;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_pin   <= (n_phase == pwbs_pkg::PH_HIGH);
            r_ready <= !n_held_valid;
            r_busy  <= (n_phase == pwbs_pkg::PH_HIGH) || (n_phase == pwbs_pkg::PH_LOW);
            r_done  <= w_done;
            r_rej   <= w_rejected;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pin_level     = r_pin;
    assign o_buffer_ready  = r_ready;
    assign o_busy_res      = r_busy;
    assign o_transfer_done = r_done;
    assign o_byte_rejected = r_rej;

endmodule

`default_nettype wire

@@ hdl/pulse_width_bit_serializer.sv @@
// Top level of the pulse-width bit serializer.
//
//  channel  direction  handshake              payload
//  in       input      i_in_valid/o_in_stall  i_req_type, i_byte_value, i_last_byte
//  out      output     o_out_valid/i_out_stall o_pin_level, o_buffer_ready, o_busy_res,
//                                             o_transfer_done, o_byte_rejected
//  cfg      input      i_cfg_we               i_cfg_index, i_cfg_wdata
//
// One transaction per cycle in and out unless stalled; results are registered.
// The front queue holds 2 transactions; the back end takes one per cycle unless stalled.
// Scaled phase lengths are registered in the cycle after a configuration write.
// Reset is synchronous and active low; it clears queue, sequencer and result valid.
// A stalled result holds its register; the queue fills and then stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module pulse_width_bit_serializer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_req_type,
    input  wire logic [7:0]                       i_byte_value,
    input  wire logic                             i_last_byte,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_pin_level,
    output logic                                  o_buffer_ready,
    output logic                                  o_busy_res,
    output logic                                  o_transfer_done,
    output logic                                  o_byte_rejected,
    input  wire logic                             i_cfg_we,
    input  wire logic [2:0]                       i_cfg_index,
    input  wire logic [pwbs_pkg::TIMING_BITS-1:0] i_cfg_wdata
);

    pwbs_pkg::t_item      w_q_item;
    pwbs_pkg::t_durations w_dur;
    logic                 w_q_valid, w_q_pop, w_unit_invalid;

    pwbs_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_dur          (w_dur),
        .o_unit_invalid (w_unit_invalid)
    );

    pwbs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item),
        .i_q_pop      (w_q_pop)
    );

    pwbs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_q_pop),
        .i_dur           (w_dur),
        .i_unit_invalid  (w_unit_invalid),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pin_level     (o_pin_level),
        .o_buffer_ready  (o_buffer_ready),
        .o_busy_res      (o_busy_res),
        .o_transfer_done (o_transfer_done),
        .o_byte_rejected (o_byte_rejected)
    );

    // A byte only waits in the holding buffer while another is on the pin
    a_held_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_buffer_ready || o_busy_res))
        else $error("holding buffer full while sequencer idle");

    // The pin is only driven high during a bit
    a_pin_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pin_level) |-> o_busy_res)
        else $error("pin high outside a bit");

    // A transaction cannot both end a transfer and be a refused load
    a_done_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_transfer_done && o_byte_rejected))
        else $error("done and rejected in one result");

    // Transfer end leaves the pin low unless the sequencer is busy with a held byte
    a_done_pin_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_transfer_done) |-> !o_pin_level || o_busy_res)
        else $error("pin high after transfer end while idle");

endmodule

`default_nettype wire
